// ===== design/bitmap_frame_allocator_top_defines.svh =====
// ----------------------------------------------------------------------------
// bitmap frame allocator assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BFA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap frame allocator check failed");

// next-cycle implication, disabled while reset is asserted
`define BFA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap frame allocator check failed");

`endif

// ===== design/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// sizes, codes and shared types of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

	// frame count must be a power of two so frame indices wrap naturally
	localparam int NUM_FRAMES = 4096;
	localparam int MAX_RUN    = 256;

	localparam int FRAME_W = $clog2(NUM_FRAMES);
	// scan offset reaches past one full sweep by up to one run
	localparam int K_W     = $clog2(NUM_FRAMES + MAX_RUN + 1);

	localparam int ACT_W   = 2;
	localparam int START_W = 12;
	localparam int LEN_W   = 9;
	localparam int STAT_W  = 2;
	localparam int GRANT_W = 12;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_FREE    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RESERVE = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 2'd2;

	typedef struct packed {
		logic               en;
		logic [FRAME_W-1:0] addr;
		logic               data;
	} map_wr_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [GRANT_W-1:0] granted;
	} result_t;

endpackage

// ===== design/bfa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_map_ram
// one bit per frame used map, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfa_map_ram
	import bfa_pkg::*;
(
	input  logic               clk,
	input  map_wr_t            wr,
	input  logic [FRAME_W-1:0] rd_addr,
	output logic               rd_data
);

	logic map_q [NUM_FRAMES];
	logic rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			map_q[wr.addr] <= wr.data;
		end
		rd_data_q <= map_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/bfa_seq.sv =====
// ----------------------------------------------------------------------------
// bfa_seq
// sequencer that walks the used map one frame a cycle: clear, scan, mark, cursor, free
// ----------------------------------------------------------------------------
module bfa_seq
	import bfa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [START_W-1:0] start_frame,
	input  logic [LEN_W-1:0]   run_length,
	output logic [FRAME_W-1:0] map_rd_addr,
	input  logic               map_rd_data,
	output map_wr_t            map_wr,
	output logic               res_valid,
	input  logic               res_ready,
	output result_t            res
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MARK  = 3'd3;
	localparam logic [2:0] S_CURS  = 3'd4;
	localparam logic [2:0] S_FREE  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]         state_q;
	logic [FRAME_W-1:0] clr_q;
	logic [FRAME_W-1:0] cursor_q;
	logic [FRAME_W-1:0] base_q;
	logic [K_W-1:0]     iss_q;
	logic               ev_vld_q;
	logic [K_W-1:0]     ev_k_q;
	logic [FRAME_W-1:0] ev_addr_q;
	logic               in_run_q;
	logic [LEN_W-1:0]   cnt_q;
	logic [FRAME_W-1:0] run_addr_q;
	logic [LEN_W-1:0]   n_q;
	logic               is_alloc_q;
	result_t            res_q;

	logic               accept;
	logic [LEN_W-1:0]   n_sat;
	logic               alloc_bad;
	logic               past_end;
	logic [LEN_W-1:0]   new_cnt;
	logic [FRAME_W-1:0] run_pos;
	logic               last_iss;
	logic               last_ev;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	assign n_sat     = (32'(run_length) > MAX_RUN) ? LEN_W'(MAX_RUN) : run_length;
	assign alloc_bad = (run_length == '0) || (32'(run_length) > MAX_RUN)
		|| (32'(run_length) > NUM_FRAMES);

	// single address adder shared by the scan, mark, cursor and free walks
	assign map_rd_addr = base_q + FRAME_W'(iss_q);

	assign past_end = (ev_k_q >= K_W'(NUM_FRAMES));
	assign new_cnt  = in_run_q ? (cnt_q + LEN_W'(1)) : LEN_W'(1);
	assign run_pos  = in_run_q ? run_addr_q : ev_addr_q;
	assign last_iss = ((iss_q + K_W'(1)) == K_W'(n_q));
	assign last_ev  = ((ev_k_q + K_W'(1)) == K_W'(n_q));

	always_comb begin
		map_wr.en   = 1'b0;
		map_wr.addr = map_rd_addr;
		map_wr.data = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				map_wr.en   = 1'b1;
				map_wr.addr = clr_q;
			end
			S_MARK: begin
				map_wr.en   = 1'b1;
				map_wr.data = 1'b1;
			end
			S_FREE: begin
				map_wr.en   = ev_vld_q && map_rd_data;
				map_wr.addr = ev_addr_q;
			end
			default: begin
				map_wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cursor_q   <= '0;
			base_q     <= '0;
			iss_q      <= '0;
			ev_vld_q   <= 1'b0;
			ev_k_q     <= '0;
			ev_addr_q  <= '0;
			in_run_q   <= 1'b0;
			cnt_q      <= '0;
			run_addr_q <= '0;
			n_q        <= '0;
			is_alloc_q <= 1'b0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + FRAME_W'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_q.status  <= ST_OK;
						res_q.granted <= '0;
						iss_q         <= '0;
						ev_vld_q      <= 1'b0;
						in_run_q      <= 1'b0;
						is_alloc_q    <= (action == ACT_ALLOC);
						base_q        <= FRAME_W'(start_frame);
						n_q           <= n_sat;
						case (action)
							ACT_ALLOC: begin
								n_q    <= run_length;
								base_q <= cursor_q;
								if (alloc_bad) begin
									res_q.status <= ST_NO_SPACE;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							ACT_FREE: begin
								state_q <= (n_sat == '0) ? S_DONE : S_FREE;
							end
							ACT_RESERVE: begin
								state_q <= (n_sat == '0) ? S_DONE : S_MARK;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					iss_q     <= iss_q + K_W'(1);
					ev_vld_q  <= 1'b1;
					ev_k_q    <= iss_q;
					ev_addr_q <= map_rd_addr;
					if (ev_vld_q) begin
						if ((!in_run_q || map_rd_data) && past_end) begin
							// a full sweep found no fitting run
							res_q.status <= ST_NO_SPACE;
							ev_vld_q     <= 1'b0;
							state_q      <= S_DONE;
						end else if (map_rd_data) begin
							in_run_q <= 1'b0;
						end else if (new_cnt == n_q) begin
							res_q.status  <= ST_OK;
							res_q.granted <= GRANT_W'(run_pos);
							base_q        <= run_pos;
							iss_q         <= '0;
							ev_vld_q      <= 1'b0;
							state_q       <= S_MARK;
						end else begin
							in_run_q <= 1'b1;
							cnt_q    <= new_cnt;
							if (!in_run_q) begin
								run_addr_q <= ev_addr_q;
							end
						end
					end
				end
				S_MARK: begin
					iss_q <= iss_q + K_W'(1);
					if (last_iss) begin
						if (is_alloc_q) begin
							// move the cursor on from just past the granted run
							iss_q    <= K_W'(n_q);
							ev_vld_q <= 1'b0;
							state_q  <= S_CURS;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CURS: begin
					iss_q     <= iss_q + K_W'(1);
					ev_vld_q  <= 1'b1;
					ev_k_q    <= iss_q;
					ev_addr_q <= map_rd_addr;
					if (ev_vld_q) begin
						if (past_end) begin
							// every frame used, cursor stays on the granted run
							cursor_q <= base_q;
							ev_vld_q <= 1'b0;
							state_q  <= S_DONE;
						end else if (!map_rd_data) begin
							cursor_q <= ev_addr_q;
							ev_vld_q <= 1'b0;
							state_q  <= S_DONE;
						end
					end
				end
				S_FREE: begin
					iss_q     <= iss_q + K_W'(1);
					ev_vld_q  <= 1'b1;
					ev_k_q    <= iss_q;
					ev_addr_q <= map_rd_addr;
					if (ev_vld_q) begin
						if (!map_rd_data) begin
							res_q.status <= ST_NOT_ALLOC;
							ev_vld_q     <= 1'b0;
							state_q      <= S_DONE;
						end else if (last_ev) begin
							ev_vld_q <= 1'b0;
							state_q  <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

endmodule

// ===== design/bitmap_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// next-fit physical frame allocator over a one bit per frame used map
// ----------------------------------------------------------------------------
// request channel (req_valid, req_stall): action, start_frame, run_length.
// response channel (rsp_valid, rsp_stall): status, granted_frame, one per
// request, in request order. a transfer happens when valid is high and stall
// is low.
// after reset the map is cleared one frame a cycle, with req_stall high
// until it is done; then the block takes one request at a time.
// the map has one read and one write port, so each walk visits one frame a
// cycle:
//   allocate: scan from the cursor for a free run, then mark the run and
//     move the cursor to the next free frame past it
//   free: walk the run, stopping at a frame not in use; reserve: mark it
// then the result is handed to the output register.
// the output register lets a new request be taken while a response waits.
// while rsp_stall is high the response holds, and a finished request waits
// in the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_top
	import bfa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [ACT_W-1:0]   action,
	input  logic [START_W-1:0] start_frame,
	input  logic [LEN_W-1:0]   run_length,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [STAT_W-1:0]  status,
	output logic [GRANT_W-1:0] granted_frame
);

	logic [FRAME_W-1:0] map_rd_addr;
	logic               map_rd_data;
	map_wr_t            map_wr;
	logic               res_valid;
	logic               res_ready;
	result_t            res;

	logic               out_valid_q;
	result_t            out_q;

	bfa_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.start_frame (start_frame),
		.run_length  (run_length),
		.map_rd_addr (map_rd_addr),
		.map_rd_data (map_rd_data),
		.map_wr      (map_wr),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	bfa_map_ram u_map (
		.clk     (clk),
		.wr      (map_wr),
		.rd_addr (map_rd_addr),
		.rd_data (map_rd_data)
	);

	// output slot is free when empty or being drained this cycle
	assign res_ready = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign status        = out_q.status;
	assign granted_frame = out_q.granted;

endmodule

// ===== design/bfa_checker.sv =====
// ----------------------------------------------------------------------------
// bfa_checker
// port-level checks on the bitmap frame allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_top_defines.svh"

module bfa_checker
	import bfa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic [ACT_W-1:0]   action,
	input logic [START_W-1:0] start_frame,
	input logic [LEN_W-1:0]   run_length,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic [STAT_W-1:0]  status,
	input logic [GRANT_W-1:0] granted_frame
);

	logic [ACT_W+START_W+LEN_W-1:0] req_payload;

	assign req_payload = {action, start_frame, run_length};

	// a stalled response holds
	`BFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(granted_frame))

	// only defined status codes leave the block
	`BFA_ASSERT_SAME(a_status_code, rsp_valid, (status == ST_OK) || (status == ST_NO_SPACE) || (status == ST_NOT_ALLOC))

	// a failed request never carries a frame index
	`BFA_ASSERT_SAME(a_fail_no_grant, rsp_valid && (status != ST_OK), granted_frame == '0)

	// one request at a time: busy right after a request transfer
	`BFA_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

	// a stalled request holds
	`BFA_ASSERT_NEXT(a_req_hold, req_valid && req_stall, req_valid && $stable(req_payload))

endmodule

bind bitmap_frame_allocator_top bfa_checker u_chk (.*);
